@@ src/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers used by the window_focus_stack rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset, uses clk and rst of the module
`define WFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define WFS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ src/wfs_pkg.sv @@
// ---------------------------------------------------------------------------
// wfs_pkg
// types and constants for the window focus stack
// ---------------------------------------------------------------------------
`default_nettype none

package wfs_pkg;

  localparam int STACK_DEPTH_DEFAULT = 16;
  localparam int ID_W = 16;

  typedef enum logic [1:0] {
    KIND_OPEN   = 2'd0,
    KIND_SWITCH = 2'd1,
    KIND_CLOSE  = 2'd2
  } cmd_kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_OPEN = 2'd1,
    OP_MOVE = 2'd2,
    OP_DROP = 2'd3
  } cell_op_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [ID_W-1:0] window_id;
  } cmd_t;

  typedef struct packed {
    logic [ID_W-1:0] focused_id;
    status_t         status;
    logic            stack_empty;
  } result_t;

  typedef struct packed {
    logic     capture;
    cell_op_t op;
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ src/window_focus_stack.sv @@
// ---------------------------------------------------------------------------
// window_focus_stack
// move-to-front stack of window identifiers, focused window on top
// the accepted word sets busy, and busy in turn sets the result strobe done
// commands are not taken while busy is high; busy is high for the one cycle
// in which the slot chain resolves the nearest match and shifts
// reset: entry count, busy and done clear; slot contents stay unknown
// results cannot be stalled, done is high for exactly one cycle
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module window_focus_stack #(
  parameter int STACK_DEPTH = wfs_pkg::STACK_DEPTH_DEFAULT
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               start,
  input  wire wfs_pkg::cmd_t cmd,
  output logic              busy,
  output logic              done,
  output wfs_pkg::result_t  result
);
  import wfs_pkg::*;

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [1:0]       kind_q;
  logic [ID_W-1:0]  id_q;
  result_t          result_next;
  cell_ctl_t        ctl;
  logic             accept;

  logic [ID_W-1:0]  slot_data [STACK_DEPTH];
  logic [STACK_DEPTH:0] hit;
  logic [STACK_DEPTH-1:0] occupied;

  assign accept = start && !busy;
  assign hit[0] = 1'b0;

  // slot 0 is the top of the stack
  for (genvar k = 0; k < STACK_DEPTH; k++) begin : g_slot
    logic [ID_W-1:0] up_data;
    logic [ID_W-1:0] down_data;

    assign occupied[k] = CNT_W'(k) < count;

    if (k == 0) begin : g_top
      assign up_data = id_q;
    end else begin : g_mid
      assign up_data = slot_data[k-1];
    end

    if (k == STACK_DEPTH - 1) begin : g_bottom
      assign down_data = slot_data[k];
    end else begin : g_inner
      assign down_data = slot_data[k+1];
    end

    wfs_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .cmp_id    (cmd.window_id),
      .occupied  (occupied[k]),
      .up_data   (up_data),
      .down_data (down_data),
      .hit_in    (hit[k]),
      .data      (slot_data[k]),
      .hit_out   (hit[k+1])
    );
  end

  always_comb begin
    ctl.capture = accept;
    ctl.op      = OP_NONE;
    count_next  = count;
    result_next.status = ST_OK;
    if (busy) begin
      case (cmd_kind_t'(kind_q))
        KIND_OPEN: begin
          if (count == CNT_W'(STACK_DEPTH)) begin
            result_next.status = ST_FULL;
          end else begin
            ctl.op     = OP_OPEN;
            count_next = count + 1'b1;
          end
        end
        KIND_SWITCH, KIND_CLOSE: begin
          if (count == '0) begin
            result_next.status = ST_EMPTY;
          end else if (!hit[STACK_DEPTH]) begin
            result_next.status = ST_NOT_FOUND;
          end else if (cmd_kind_t'(kind_q) == KIND_SWITCH) begin
            ctl.op = OP_MOVE;
          end else begin
            ctl.op     = OP_DROP;
            count_next = count - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    result_next.stack_empty = (count_next == '0);
    if (count_next == '0) begin
      result_next.focused_id = '0;
    end else begin
      case (ctl.op)
        OP_OPEN, OP_MOVE: result_next.focused_id = id_q;
        // the top only changes when the match sits in the top slot
        OP_DROP:          result_next.focused_id = hit[1] ? slot_data[1] : slot_data[0];
        default:          result_next.focused_id = slot_data[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      busy  <= accept;
      done  <= busy;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q <= cmd.kind;
      id_q   <= cmd.window_id;
    end
    if (busy) begin
      result <= result_next;
    end
  end

  `WFS_ASSERT(a_count_bound, count <= CNT_W'(STACK_DEPTH), "entry count above depth")
  `WFS_ASSERT(a_accept_busy, accept |=> (busy && !done), "accepted word not in progress")
  `WFS_ASSERT(a_done_after, done |-> ($past(busy) && !busy), "done without a command")
  `WFS_ASSERT(a_empty_zero, (done && result.stack_empty) |-> (result.focused_id == '0),
              "empty stack reports an identifier")
  `WFS_ASSERT_ALWAYS(a_reset_idle, $past(rst) |-> (!busy && !done), "not idle after reset")

endmodule

`default_nettype wire

@@ src/wfs_cell.sv @@
// ---------------------------------------------------------------------------
// wfs_cell
// one stack slot: holds an identifier, compares it, shifts with neighbors
// ---------------------------------------------------------------------------
`default_nettype none

module wfs_cell (
  input  wire                        clk,
  input  wire wfs_pkg::cell_ctl_t    ctl,
  input  wire [wfs_pkg::ID_W-1:0]    cmp_id,
  input  wire                        occupied,
  input  wire [wfs_pkg::ID_W-1:0]    up_data,
  input  wire [wfs_pkg::ID_W-1:0]    down_data,
  input  wire                        hit_in,
  output logic [wfs_pkg::ID_W-1:0]   data,
  output logic                       hit_out
);
  import wfs_pkg::*;

  logic match;
  logic load_up;
  logic load_down;

  // hit ripples from the top slot downward, so only the nearest match counts
  assign hit_out = hit_in | match;

  always_comb begin
    load_up   = 1'b0;
    load_down = 1'b0;
    case (ctl.op)
      OP_NONE: begin
      end
      OP_OPEN: load_up = 1'b1;
      // slots from the top down to the match take the one above
      OP_MOVE: load_up = ~hit_in;
      // slots from the match downward take the one below
      OP_DROP: load_down = hit_out;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      match <= occupied && (data == cmp_id);
    end
    if (load_up) begin
      data <= up_data;
    end else if (load_down) begin
      data <= down_data;
    end
  end

endmodule

`default_nettype wire
